// File: design/matrix_square_plus_transpose_assert.svh
// Assertion macros used by the top design file.
// Every check is sampled on the rising edge of clk and is off while arst_n is low.
`ifndef MATRIX_SQUARE_PLUS_TRANSPOSE_ASSERT_SVH
`define MATRIX_SQUARE_PLUS_TRANSPOSE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSQT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MSQT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |=> (cons)) else $error(msg);

`endif

// File: design/msqt_pkg.sv
package msqt_pkg;

	// Width of one result and of the byte-padded output data bus.
	localparam int SUM_W     = 35;
	localparam int OUT_TDATA_W = ((SUM_W + 7) / 8) * 8;

	// Width of the size register.
	localparam int CFG_W = 4;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ISSUE,
		ST_DRAIN,
		ST_RESULT
	} state_t;

	// Tags that travel with each operand pair through the MAC.
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} mac_ctrl_t;

endpackage

// File: design/msqt_mac.sv
module msqt_mac #(
	parameter int ELEM_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  msqt_pkg::mac_ctrl_t                   ctrl,
	input  logic signed [ELEM_BITS-1:0]           op_a,
	input  logic signed [ELEM_BITS-1:0]           op_b,
	input  logic signed [ELEM_BITS-1:0]           op_add,
	output logic signed [msqt_pkg::SUM_W-1:0]     acc,
	output logic                                  done
);

	localparam int PROD_W = 2 * ELEM_BITS;

	logic signed [PROD_W-1:0]            prod_s1;
	msqt_pkg::mac_ctrl_t                 ctrl_s1;
	logic signed [msqt_pkg::SUM_W-1:0]   acc_q;
	logic                                done_q;

	// Multiply stage: product and tags registered together.
	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1 <= ctrl;
		end
	end

	// Accumulate stage. The first product of a sum also picks up the
	// transposed term, so no separate clearing cycle is needed. The sum
	// is kept modulo 2^SUM_W, which matches the exact result in range.
	always_ff @(posedge clk) begin
		if (ctrl_s1.valid) begin
			if (ctrl_s1.first) begin
				acc_q <= msqt_pkg::SUM_W'(prod_s1) + msqt_pkg::SUM_W'(op_add);
			end else begin
				acc_q <= acc_q + msqt_pkg::SUM_W'(prod_s1);
			end
		end
	end

	// One-cycle pulse once the last product of a sum is in.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl_s1.valid && ctrl_s1.last;
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule

// File: design/matrix_square_plus_transpose.sv
// Channel   Direction  Handshake           Payload
// s_        in         s_tvalid/s_tready   s_tdata: element
// m_        out        m_tvalid/m_tready   m_tdata: sum_value, m_tlast: last_of_run
// cfg_      in         cfg_we              cfg_wdata: size_in_use
//
// Loading takes one beat per cycle for all 2*N*N elements of A and B.
// After the last element of B each result is formed by N operand reads into
// the single shared multiply-accumulate unit, then passes the read, multiply
// and accumulate registers and then the output register. While the results
// are computed s_tready is low, and a stalled m_tready holds the sequencer
// at the next result.
// Reset leaves N at MAX_DIM and the load position at the start of A.
`include "matrix_square_plus_transpose_assert.svh"

module matrix_square_plus_transpose #(
	parameter int MAX_DIM   = 8,
	parameter int ELEM_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Bits from low: element [ELEM_BITS-1:0], zero fill up to a whole byte.
	input  logic [((ELEM_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// Bits from low: sum_value [34:0], zero fill [39:35].
	output logic [msqt_pkg::OUT_TDATA_W-1:0]      m_tdata,
	output logic                                  m_tlast,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	input  logic                                  cfg_we,
	input  logic [msqt_pkg::CFG_W-1:0]            cfg_wdata
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

	// Row-major store address of entry (r, c).
	function automatic logic [ADDR_W-1:0] rc_addr(input logic [DIM_W-1:0] r,
	                                              input logic [DIM_W-1:0] c);
		logic [ADDR_W-1:0] base;
		base = ADDR_W'(r) * ADDR_W'(MAX_DIM);
		return base + ADDR_W'(c);
	endfunction

	msqt_pkg::state_t                     state_q, state_d;
	logic [msqt_pkg::CFG_W-1:0]           size_q;
	logic [DIM_W-1:0]                     nm1;
	logic [DIM_W-1:0]                     ld_row_q, ld_col_q;
	logic                                 ld_b_q;
	logic [DIM_W-1:0]                     i_q, j_q, k_q;
	logic                                 in_accept, ld_end, ij_end;
	logic                                 issue_en, out_free, out_load;
	logic signed [ELEM_BITS-1:0]          element;
	logic [ADDR_W-1:0]                    wr_addr;
	logic signed [ELEM_BITS-1:0]          a_mem [DEPTH];
	logic signed [ELEM_BITS-1:0]          b_mem [DEPTH];
	logic signed [ELEM_BITS-1:0]          a_ik_q, a_kj_q, b_ji_q;
	msqt_pkg::mac_ctrl_t                  rd_ctrl_q;
	logic signed [msqt_pkg::SUM_W-1:0]    mac_acc;
	logic                                 mac_done;
	logic signed [msqt_pkg::SUM_W-1:0]    sum_q;
	logic                                 last_q, valid_q;

	// Size register; a write also restarts loading at the first element of A.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= msqt_pkg::CFG_W'(MAX_DIM);
		end else if (cfg_we) begin
			size_q <= cfg_wdata;
		end
	end

	// Dimension in use minus one: zero acts as one, oversize as the maximum.
	always_comb begin
		priority if (size_q == '0) begin
			nm1 = '0;
		end else if (size_q > msqt_pkg::CFG_W'(MAX_DIM)) begin
			nm1 = DIM_W'(MAX_DIM - 1);
		end else begin
			nm1 = DIM_W'(size_q - msqt_pkg::CFG_W'(1));
		end
	end

	assign element   = $signed(s_tdata[ELEM_BITS-1:0]);
	assign in_accept = s_tvalid && s_tready;
	assign ld_end    = ld_b_q && (ld_row_q == nm1) && (ld_col_q == nm1);
	assign ij_end    = (i_q == nm1) && (j_q == nm1);
	assign out_free  = !valid_q || m_tready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			msqt_pkg::ST_LOAD: begin
				if (in_accept && ld_end) begin
					state_d = msqt_pkg::ST_ISSUE;
				end
			end
			msqt_pkg::ST_ISSUE: begin
				if (k_q == nm1) begin
					state_d = msqt_pkg::ST_DRAIN;
				end
			end
			msqt_pkg::ST_DRAIN: begin
				if (mac_done) begin
					state_d = msqt_pkg::ST_RESULT;
				end
			end
			msqt_pkg::ST_RESULT: begin
				if (out_free) begin
					state_d = ij_end ? msqt_pkg::ST_LOAD : msqt_pkg::ST_ISSUE;
				end
			end
			default: state_d = msqt_pkg::ST_LOAD;
		endcase
	end

	// State outputs.
	always_comb begin
		s_tready = 1'b0;
		issue_en = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			msqt_pkg::ST_LOAD:   s_tready = 1'b1;
			msqt_pkg::ST_ISSUE:  issue_en = 1'b1;
			msqt_pkg::ST_DRAIN:  ;
			msqt_pkg::ST_RESULT: out_load = out_free;
			default:             ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msqt_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Load position: row and column within A, then within B.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_row_q <= '0;
			ld_col_q <= '0;
			ld_b_q   <= 1'b0;
		end else begin
			priority if (cfg_we) begin
				ld_row_q <= '0;
				ld_col_q <= '0;
				ld_b_q   <= 1'b0;
			end else if (in_accept) begin
				if (ld_col_q != nm1) begin
					ld_col_q <= ld_col_q + DIM_W'(1);
				end else begin
					ld_col_q <= '0;
					if (ld_row_q != nm1) begin
						ld_row_q <= ld_row_q + DIM_W'(1);
					end else begin
						ld_row_q <= '0;
						ld_b_q   <= !ld_b_q;
					end
				end
			end
		end
	end

	// Result counters: k steps through the products of one sum, (i, j) the results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else begin
			if (issue_en) begin
				k_q <= (k_q == nm1) ? '0 : k_q + DIM_W'(1);
			end
			if (out_load) begin
				if (j_q != nm1) begin
					j_q <= j_q + DIM_W'(1);
				end else begin
					j_q <= '0;
					i_q <= (i_q == nm1) ? '0 : i_q + DIM_W'(1);
				end
			end
		end
	end

	// Matrix stores: one write port, registered reads.
	assign wr_addr = rc_addr(ld_row_q, ld_col_q);

	always_ff @(posedge clk) begin
		if (in_accept && !ld_b_q) begin
			a_mem[wr_addr] <= element;
		end
		if (issue_en) begin
			a_ik_q <= a_mem[rc_addr(i_q, k_q)];
			a_kj_q <= a_mem[rc_addr(k_q, j_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && ld_b_q) begin
			b_mem[wr_addr] <= element;
		end
		if (issue_en && (k_q == '0)) begin
			b_ji_q <= b_mem[rc_addr(j_q, i_q)];
		end
	end

	// Tags that follow the read data into the MAC.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ctrl_q <= '0;
		end else begin
			rd_ctrl_q.valid <= issue_en;
			rd_ctrl_q.first <= (k_q == '0);
			rd_ctrl_q.last  <= (k_q == nm1);
		end
	end

	msqt_mac #(
		.ELEM_BITS(ELEM_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (rd_ctrl_q),
		.op_a   (a_ik_q),
		.op_b   (a_kj_q),
		.op_add (b_ji_q),
		.acc    (mac_acc),
		.done   (mac_done)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sum_q  <= mac_acc;
			last_q <= ij_end;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = msqt_pkg::OUT_TDATA_W'($unsigned(sum_q));
	assign m_tlast  = last_q;

	// Checks on the sequencer and the MAC.
	`MSQT_ASSERT_NOW(a_done_in_drain, mac_done, state_q == msqt_pkg::ST_DRAIN, "MAC done outside drain")
	`MSQT_ASSERT_NOW(a_k_in_range, state_q == msqt_pkg::ST_ISSUE, k_q <= nm1, "product index beyond size")
	`MSQT_ASSERT_NEXT(a_run_starts_at_origin, state_q == msqt_pkg::ST_LOAD && state_d == msqt_pkg::ST_ISSUE, i_q == '0 && j_q == '0 && k_q == '0, "run does not start at the first result")
	`MSQT_ASSERT_NEXT(a_last_result_flagged, out_load && ij_end, m_tvalid && m_tlast, "final result not flagged")

endmodule

// File: bench/matrix_square_plus_transpose_checker.sv
`timescale 1ns / 1ps

// Watches the element, result and size channels of the block. It keeps its own copy of both
// matrices and the size, works out C = A*A + B transposed when the last element of B arrives,
// and compares every result beat in order against those values.
module matrix_square_plus_transpose_checker #(
	parameter int MAX_DIM   = 8,
	parameter int ELEM_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [((ELEM_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	input  logic                                   s_tvalid,
	input  logic                                   s_tready,
	input  logic [msqt_pkg::OUT_TDATA_W-1:0]       m_tdata,
	input  logic                                   m_tlast,
	input  logic                                   m_tvalid,
	input  logic                                   m_tready,
	input  logic                                   cfg_we,
	input  logic [msqt_pkg::CFG_W-1:0]             cfg_wdata,
	output int                                     errors,
	output int                                     pending
);

	// One predicted result beat.
	typedef struct packed {
		logic [msqt_pkg::SUM_W-1:0] sum;
		logic                       is_last;
	} product_t;

	logic signed [ELEM_BITS-1:0] a_mat [MAX_DIM * MAX_DIM];
	logic signed [ELEM_BITS-1:0] b_mat [MAX_DIM * MAX_DIM];
	logic [msqt_pkg::CFG_W-1:0]  size_reg;
	int                          fill;
	product_t                    awaited [$];

	// A size of zero behaves as one; anything above the maximum behaves as the maximum.
	function automatic int side_length(input logic [msqt_pkg::CFG_W-1:0] size);
		if (size == '0)
			return 1;
		if (int'(size) > MAX_DIM)
			return MAX_DIM;
		return int'(size);
	endfunction

	// Full-precision C[i][j] for the whole matrix, in row-major order.
	task automatic queue_products(input int n);
		longint   acc;
		product_t p;
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j < n; j++) begin
				acc = 0;
				for (int k = 0; k < n; k++)
					acc += longint'(a_mat[i * MAX_DIM + k]) * longint'(a_mat[k * MAX_DIM + j]);
				acc += longint'(b_mat[j * MAX_DIM + i]);
				p.sum     = acc[msqt_pkg::SUM_W-1:0];
				p.is_last = (i == n - 1) && (j == n - 1);
				awaited.push_back(p);
			end
		end
	endtask

	// Store one element of A or B; the last element of B completes the run.
	task automatic take_element(input logic signed [ELEM_BITS-1:0] value);
		int n;
		int sq;
		n  = side_length(size_reg);
		sq = n * n;
		if (fill >= 2 * sq)
			fill = 0;
		if (fill < sq)
			a_mat[(fill / n) * MAX_DIM + fill % n] = value;
		else
			b_mat[((fill - sq) / n) * MAX_DIM + (fill - sq) % n] = value;
		if (fill + 1 < 2 * sq) begin
			fill++;
		end else begin
			fill = 0;
			queue_products(n);
		end
	endtask

	// Compare one result beat with the oldest prediction.
	task automatic check_result(input logic [msqt_pkg::SUM_W-1:0] sum, input logic is_last);
		product_t want;
		if (awaited.size() == 0) begin
			$display("%0t: result beat %0d (last %b) arrived with nothing expected",
				$time, $signed(sum), is_last);
			errors++;
		end else begin
			want = awaited.pop_front();
			if (sum !== want.sum) begin
				$display("%0t: sum mismatch, expected %0d, actual %0d",
					$time, $signed(want.sum), $signed(sum));
				errors++;
			end
			if (is_last !== want.is_last) begin
				$display("%0t: last flag mismatch, expected %b, actual %b",
					$time, want.is_last, is_last);
				errors++;
			end
		end
	endtask

	// Track size writes, element beats and result beats at each rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_reg = msqt_pkg::CFG_W'(MAX_DIM);
			fill     = 0;
			awaited.delete();
			pending  = 0;
			errors   = 0;
		end else begin
			// A size write also drops any partly loaded run.
			if (cfg_we) begin
				size_reg = cfg_wdata;
				fill     = 0;
			end
			if (s_tvalid && s_tready)
				take_element(s_tdata[ELEM_BITS-1:0]);
			if (m_tvalid && m_tready)
				check_result(m_tdata[msqt_pkg::SUM_W-1:0], m_tlast);
			pending = awaited.size();
		end
	end

endmodule

// File: bench/matrix_square_plus_transpose_tb.sv
`timescale 1ns / 1ps

module matrix_square_plus_transpose_tb;

	localparam int MAX_DIM     = 8;
	localparam int ELEM_BITS   = 16;
	localparam int S_TDATA_W   = ((ELEM_BITS + 7) / 8) * 8;
	localparam int SETTLE      = MAX_DIM + 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 140;

	localparam logic signed [ELEM_BITS-1:0] ELEM_MIN = {1'b1, {(ELEM_BITS - 1){1'b0}}};
	localparam logic signed [ELEM_BITS-1:0] ELEM_MAX = {1'b0, {(ELEM_BITS - 1){1'b1}}};

	logic                               clk       = 1'b0;
	logic                               arst_n    = 1'b0;
	logic [S_TDATA_W-1:0]               s_tdata   = '0;
	logic                               s_tvalid  = 1'b0;
	logic                               s_tready;
	logic [msqt_pkg::OUT_TDATA_W-1:0]   m_tdata;
	logic                               m_tlast;
	logic                               m_tvalid;
	logic                               m_tready  = 1'b0;
	logic                               cfg_we    = 1'b0;
	logic [msqt_pkg::CFG_W-1:0]         cfg_wdata = '0;

	int errors;
	int pending;
	int cycles = 0;
	// While set, neither side inserts idle cycles.
	logic steady = 1'b0;

	matrix_square_plus_transpose #(
		.MAX_DIM  (MAX_DIM),
		.ELEM_BITS(ELEM_BITS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	matrix_square_plus_transpose_checker #(
		.MAX_DIM  (MAX_DIM),
		.ELEM_BITS(ELEM_BITS)
	) sum_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.errors   (errors),
		.pending  (pending)
	);

	always #5 clk = ~clk;

	// Result side stalls in about a third of the cycles while steady is clear.
	always @(negedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= 35);
	end

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic int side_length(input logic [msqt_pkg::CFG_W-1:0] size);
		if (size == '0)
			return 1;
		if (int'(size) > MAX_DIM)
			return MAX_DIM;
		return int'(size);
	endfunction

	// Mostly full-range values, with the extremes and small values mixed in.
	function automatic logic signed [ELEM_BITS-1:0] pick_element();
		case ($urandom_range(0, 7))
			0: return ELEM_MIN;
			1: return ELEM_MAX;
			2: return ELEM_BITS'($signed($urandom_range(0, 8)) - 4);
			default: return ELEM_BITS'($urandom);
		endcase
	endfunction

	// Send one element beat; entered and left at a falling edge.
	task automatic put_element(input logic signed [ELEM_BITS-1:0] value);
		while (!steady && $urandom_range(0, 99) < 35) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	// Write the size register while the block is idle.
	task automatic set_size(input logic [msqt_pkg::CFG_W-1:0] size);
		cfg_we    <= 1'b1;
		cfg_wdata <= size;
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
	endtask

	// Wait until every predicted result has come out, then let the block settle.
	task automatic wait_drained();
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Load part of a run and leave it unfinished.
	task automatic load_partial(input int count);
		for (int e = 0; e < count; e++)
			put_element(pick_element());
		s_tvalid <= 1'b0;
		repeat (SETTLE) @(negedge clk);
	endtask

	initial begin
		logic [msqt_pkg::CFG_W-1:0] size;
		int                         dim;
		int                         runs;
		int                         random_items;
		int                         phase;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Partial run at the reset size, then dropped by a write of size zero.
		put_element(ELEM_MAX);
		put_element(ELEM_MIN);
		put_element(16'sd1);
		put_element(-16'sd1);
		put_element(16'sd0);
		s_tvalid <= 1'b0;
		repeat (SETTLE) @(negedge clk);
		set_size('0);

		// One by one runs at the extremes.
		put_element(ELEM_MIN);
		put_element(ELEM_MAX);
		put_element(ELEM_MAX);
		put_element(ELEM_MIN);
		put_element(-16'sd1);
		put_element(16'sd0);
		s_tvalid <= 1'b0;
		wait_drained();

		// Two by two: largest sum, then an asymmetric B to expose the transpose.
		set_size(msqt_pkg::CFG_W'(2));
		for (int e = 0; e < 4; e++)
			put_element(ELEM_MIN);
		for (int e = 0; e < 4; e++)
			put_element(ELEM_MAX);
		put_element(ELEM_MIN);
		put_element(ELEM_MAX);
		put_element(ELEM_MAX);
		put_element(ELEM_MIN);
		put_element(ELEM_MIN);
		put_element(16'sd0);
		put_element(16'sd1);
		put_element(-16'sd1);
		s_tvalid <= 1'b0;
		wait_drained();

		// Random phases: first a full-size run through a size above the maximum, with no
		// idling on either side, then small sizes.
		random_items = 0;
		phase        = 0;
		while (random_items < RANDOM_ITEMS) begin
			if (phase == 0)
				size = '1;
			else
				size = msqt_pkg::CFG_W'($urandom_range(0, 5));
			dim    = side_length(size);
			steady = (phase == 0);
			set_size(size);

			// Now and then a broken run that the next write throws away.
			if ($urandom_range(0, 3) == 0) begin
				load_partial($urandom_range(1, (dim > 2) ? 12 : 2 * dim * dim - 1));
				set_size(size);
			end

			runs = (dim == MAX_DIM) ? 1 : $urandom_range(1, 2);
			for (int r = 0; r < runs; r++) begin
				for (int e = 0; e < 2 * dim * dim; e++) begin
					put_element(pick_element());
					random_items++;
				end
			end
			s_tvalid <= 1'b0;
			wait_drained();
			phase++;
		end
		steady = 1'b0;

		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: files.f
+incdir+design
design/msqt_pkg.sv
design/msqt_mac.sv
design/matrix_square_plus_transpose.sv
bench/matrix_square_plus_transpose_checker.sv
bench/matrix_square_plus_transpose_tb.sv
